/* hdl/mrrfa_pkg.sv */
// mrrfa_pkg: shared widths, reset values and register indexes for the
// median rate-of-rise fire alarm core. No dependencies.
`default_nettype none

package mrrfa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RISE_W   = 15;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MEDIAN_TAPS_DEF  = 5;
    localparam int WINDOW_DEPTH_DEF = 30;

    // recount of high flags after a threshold change, in groups of this size
    localparam int GROUP_SIZE = 8;
    localparam int GROUP_W    = 4;

    localparam logic [RISE_W-1:0]          RISE_THR_RST = RISE_W'(8);
    localparam logic signed [SAMPLE_W-1:0] HIGH_THR_RST = SAMPLE_W'(58);
    localparam logic [CNT_W-1:0]           HIGH_CNT_RST = CNT_W'(27);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RISE_THR = 2'd0,
        REG_HIGH_THR = 2'd1,
        REG_HIGH_CNT = 2'd2
    } cfg_idx_t;

endpackage : mrrfa_pkg

`default_nettype wire

/* hdl/mrrfa_if.sv */
// mrrfa_if: valid/ready channel interfaces for samples and results.
// Depends on mrrfa_pkg for field widths.
`default_nettype none

interface mrrfa_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mrrfa_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface : mrrfa_in_if

interface mrrfa_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  alarm;
    logic signed [mrrfa_pkg::SAMPLE_W-1:0] smoothed;
    logic                                  smoothed_valid;
    logic                                  rise_trip;
    logic                                  high_trip;

    modport source (output valid, output alarm, output smoothed, output smoothed_valid,
                    output rise_trip, output high_trip, input ready);
    modport sink   (input valid, input alarm, input smoothed, input smoothed_valid,
                    input rise_trip, input high_trip, output ready);
endinterface : mrrfa_out_if

`default_nettype wire

/* hdl/median_rate_of_rise_fire_alarm_core.sv */
// Median-filtered rate-of-rise fire alarm core (top level).
// Depends on mrrfa_pkg and the channel interfaces in mrrfa_if.sv.
// Usage:
//   in_ch  carries one signed temperature sample per transfer.
//   out_ch carries one result per sample: latched alarm, the median of the
//          last MEDIAN_TAPS samples (with its valid flag) and the two trip
//          flags. Results come out in sample order, one per sample.
//   cfg_*  writes rise_threshold (0), high_threshold (1) and
//          high_count_needed (2); other indexes are ignored. Write only while
//          no sample is in flight.
// out_ch.valid rises once the sample has passed the input register and then,
// through median sort, window shift and trip compares, the result register.
// One sample per cycle is sustained while out_ch is ready and no recount runs.
// A write of high_threshold re-evaluates every window entry against the new
// level and recounts them in states RC_GROUP and RC_TOTAL, with in_ch.ready low.
// Reset clears the fill counts, high count, alarm and pipeline valids and
// loads the register defaults (8, 58, 27).
// When out_ch stalls, the result register holds and the input register
// fills, so in_ch.ready drops one sample later. Once the alarm is latched,
// samples are consumed without changing state until reset.
`default_nettype none

module median_rate_of_rise_fire_alarm_core #(
    parameter int MEDIAN_TAPS  = mrrfa_pkg::MEDIAN_TAPS_DEF,
    parameter int WINDOW_DEPTH = mrrfa_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    mrrfa_in_if.sink                                in_ch,
    mrrfa_out_if.source                             out_ch,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mrrfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mrrfa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int SW       = mrrfa_pkg::SAMPLE_W;
    localparam int RFILL_W  = $clog2(MEDIAN_TAPS + 1);
    localparam int RANK_W   = $clog2(MEDIAN_TAPS);
    localparam int WFILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int TALLY_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W    = (TALLY_W > mrrfa_pkg::CNT_W) ? TALLY_W : mrrfa_pkg::CNT_W;
    localparam int NGRP     = (WINDOW_DEPTH + mrrfa_pkg::GROUP_SIZE - 1) / mrrfa_pkg::GROUP_SIZE;
    localparam int GW       = mrrfa_pkg::GROUP_W;
    localparam logic [RANK_W-1:0]  MID_RANK  = RANK_W'((MEDIAN_TAPS - 1) / 2);
    localparam logic [RFILL_W-1:0] TAPS_FULL = RFILL_W'(MEDIAN_TAPS);
    localparam logic [WFILL_W-1:0] WIN_FULL  = WFILL_W'(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        RC_IDLE  = 3'b001,
        RC_GROUP = 3'b010,
        RC_TOTAL = 3'b100
    } rc_state_t;

    // configuration
    logic [mrrfa_pkg::RISE_W-1:0]  rise_thr_reg;
    logic signed [SW-1:0]          high_thr_reg;
    logic [mrrfa_pkg::CNT_W-1:0]   high_cnt_reg;

    // input stage
    logic                 s1_valid_reg, s1_valid_next;
    logic signed [SW-1:0] sample_reg;

    // detector state
    logic signed [SW-1:0]  raw_reg [MEDIAN_TAPS];
    logic [RFILL_W-1:0]    raw_fill_reg, raw_fill_next;
    logic signed [SW-1:0]  win_reg [WINDOW_DEPTH];
    logic [WFILL_W-1:0]    win_fill_reg, win_fill_next;
    logic [WINDOW_DEPTH-1:0] flags_reg, flags_next;
    logic [TALLY_W-1:0]    tally_reg, tally_next;
    logic                  alarm_reg, alarm_next;
    rc_state_t             rc_state_reg, rc_state_next;
    logic [GW-1:0]         grp_cnt_reg [NGRP];

    // result stage
    logic                 out_valid_reg, out_valid_next;
    logic                 out_alarm_reg;
    logic signed [SW-1:0] out_smoothed_reg;
    logic                 out_smoothed_valid_reg;
    logic                 out_rise_reg;
    logic                 out_high_reg;

    // datapath
    logic signed [SW-1:0]  cand [MEDIAN_TAPS];
    logic [RANK_W-1:0]     rank [MEDIAN_TAPS];
    logic signed [SW-1:0]  med;
    logic                  med_valid;
    logic                  new_flag;
    logic                  win_full;
    logic signed [SW:0]    rise_diff;
    logic                  rise_hit;
    logic                  high_hit;
    logic                  step_alarm;
    logic [WINDOW_DEPTH-1:0] flags_recalc;
    logic [TALLY_W-1:0]    grp_total;

    logic rc_idle;
    logic adv;
    logic in_xfer;
    logic thr_write;

    assign rc_idle   = (rc_state_reg == RC_IDLE);
    assign adv       = s1_valid_reg && (!out_valid_reg || out_ch.ready) && rc_idle;
    assign in_ch.ready = rc_idle && (!s1_valid_reg || adv);
    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign thr_write = cfg_wr_en && (cfg_index == mrrfa_pkg::REG_HIGH_THR);

    // raw taps after this sample shifts in
    always_comb
    begin
        for (int k = 0; k < MEDIAN_TAPS - 1; k++)
        begin
            cand[k] = raw_reg[k + 1];
        end
        cand[MEDIAN_TAPS - 1] = sample_reg;
    end

    // rank selection: ties broken by position, so ranks are a permutation
    always_comb
    begin
        for (int i = 0; i < MEDIAN_TAPS; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < MEDIAN_TAPS; j++)
            begin
                if ((cand[j] < cand[i]) || ((j < i) && (cand[j] == cand[i])))
                begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
        med = '0;
        for (int i = 0; i < MEDIAN_TAPS; i++)
        begin
            if (rank[i] == MID_RANK)
            begin
                med = med | cand[i];
            end
        end
    end

    always_comb
    begin
        raw_fill_next = (raw_fill_reg == TAPS_FULL) ? raw_fill_reg
                                                    : raw_fill_reg + RFILL_W'(1);
        med_valid  = (raw_fill_next == TAPS_FULL);
        new_flag   = (med >= high_thr_reg);
        if (med_valid)
        begin
            win_fill_next = (win_fill_reg == WIN_FULL) ? win_fill_reg
                                                       : win_fill_reg + WFILL_W'(1);
            tally_next    = tally_reg + TALLY_W'(new_flag) - TALLY_W'(flags_reg[0]);
        end
        else
        begin
            win_fill_next = win_fill_reg;
            tally_next    = tally_reg;
        end
        win_full   = (win_fill_next == WIN_FULL);
        // after the shift the oldest entry is the current second-oldest
        rise_diff  = {med[SW-1], med} - {win_reg[1][SW-1], win_reg[1]};
        rise_hit   = win_full && (rise_diff >= $signed({2'b00, rise_thr_reg}));
        high_hit   = win_full && (CMP_W'(tally_next) >= CMP_W'(high_cnt_reg));
        step_alarm = rise_hit || high_hit;
    end

    // re-evaluate each occupied entry against a newly written level
    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            flags_recalc[i] = (win_reg[i] >= $signed(cfg_wdata[SW-1:0]))
                           && (WFILL_W'(WINDOW_DEPTH - i) <= win_fill_reg);
        end
    end

    always_comb
    begin
        grp_total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_total = grp_total + TALLY_W'(grp_cnt_reg[g]);
        end
    end

    function automatic logic [GW-1:0] group_count(input int g);
        logic [GW-1:0] n;
        n = '0;
        for (int b = 0; b < mrrfa_pkg::GROUP_SIZE; b++)
        begin
            if (g * mrrfa_pkg::GROUP_SIZE + b < WINDOW_DEPTH)
            begin
                n = n + GW'(flags_reg[g * mrrfa_pkg::GROUP_SIZE + b]);
            end
        end
        return n;
    endfunction

    always_comb
    begin
        s1_valid_next  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        out_valid_next = adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
        alarm_next     = alarm_reg;
        flags_next     = flags_reg;
        rc_state_next  = rc_state_reg;
        if (adv && !alarm_reg)
        begin
            alarm_next = step_alarm;
            if (med_valid)
            begin
                flags_next = {new_flag, flags_reg[WINDOW_DEPTH-1:1]};
            end
        end
        if (thr_write)
        begin
            flags_next = flags_recalc;
        end
        case (rc_state_reg)
            RC_IDLE:  rc_state_next = thr_write ? RC_GROUP : RC_IDLE;
            RC_GROUP: rc_state_next = RC_TOTAL;
            RC_TOTAL: rc_state_next = RC_IDLE;
            default:  rc_state_next = RC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_thr_reg  <= mrrfa_pkg::RISE_THR_RST;
            high_thr_reg  <= mrrfa_pkg::HIGH_THR_RST;
            high_cnt_reg  <= mrrfa_pkg::HIGH_CNT_RST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            raw_fill_reg  <= '0;
            win_fill_reg  <= '0;
            flags_reg     <= '0;
            tally_reg     <= '0;
            alarm_reg     <= 1'b0;
            rc_state_reg  <= RC_IDLE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            alarm_reg     <= alarm_next;
            flags_reg     <= flags_next;
            rc_state_reg  <= rc_state_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    mrrfa_pkg::REG_RISE_THR: rise_thr_reg <= cfg_wdata[mrrfa_pkg::RISE_W-1:0];
                    mrrfa_pkg::REG_HIGH_THR: high_thr_reg <= $signed(cfg_wdata[SW-1:0]);
                    mrrfa_pkg::REG_HIGH_CNT: high_cnt_reg <= cfg_wdata[mrrfa_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (adv && !alarm_reg)
            begin
                raw_fill_reg <= raw_fill_next;
                win_fill_reg <= win_fill_next;
                tally_reg    <= tally_next;
            end
            else if (rc_state_reg == RC_TOTAL)
            begin
                tally_reg <= grp_total;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= in_ch.sample;
        end
        if (adv && !alarm_reg)
        begin
            for (int k = 0; k < MEDIAN_TAPS; k++)
            begin
                raw_reg[k] <= cand[k];
            end
            if (med_valid)
            begin
                for (int k = 0; k < WINDOW_DEPTH - 1; k++)
                begin
                    win_reg[k] <= win_reg[k + 1];
                end
                win_reg[WINDOW_DEPTH - 1] <= med;
            end
        end
        if (rc_state_reg == RC_GROUP)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_cnt_reg[g] <= group_count(g);
            end
        end
        if (adv)
        begin
            if (alarm_reg)
            begin
                out_alarm_reg          <= 1'b1;
                out_smoothed_reg       <= '0;
                out_smoothed_valid_reg <= 1'b0;
                out_rise_reg           <= 1'b0;
                out_high_reg           <= 1'b0;
            end
            else
            begin
                out_alarm_reg          <= step_alarm;
                out_smoothed_reg       <= med_valid ? med : '0;
                out_smoothed_valid_reg <= med_valid;
                out_rise_reg           <= rise_hit;
                out_high_reg           <= high_hit;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.alarm          = out_alarm_reg;
    assign out_ch.smoothed       = out_smoothed_reg;
    assign out_ch.smoothed_valid = out_smoothed_valid_reg;
    assign out_ch.rise_trip      = out_rise_reg;
    assign out_ch.high_trip      = out_high_reg;

endmodule : median_rate_of_rise_fire_alarm_core

`default_nettype wire

/* hdl/mrrfa_checker.sv */
// mrrfa_checker: port-level assertions for the fire alarm core, attached
// by the bind at the end of this file. Depends on mrrfa_pkg.
`default_nettype none

module mrrfa_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic                              alarm,
    input wire logic signed [mrrfa_pkg::SAMPLE_W-1:0] smoothed,
    input wire logic                              smoothed_valid,
    input wire logic                              rise_trip,
    input wire logic                              high_trip
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(alarm) && $stable(smoothed)
            && $stable(smoothed_valid) && $stable(rise_trip) && $stable(high_trip))
        else $error("result changed while stalled");

    // a trip only happens on a full window, so a median exists and the alarm is set
    a_trip_sets_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rise_trip || high_trip) |-> alarm && smoothed_valid)
        else $error("trip without alarm or median");

    // no median means a zero smoothed field
    a_no_median_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !smoothed_valid |-> smoothed == '0)
        else $error("smoothed field nonzero without median");

    // after the alarm has latched, results carry nothing but the alarm
    a_latched_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm && !rise_trip && !high_trip |-> !smoothed_valid)
        else $error("latched alarm result carries a median");

endmodule : mrrfa_checker

bind median_rate_of_rise_fire_alarm_core mrrfa_checker u_mrrfa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .alarm          (out_ch.alarm),
    .smoothed       (out_ch.smoothed),
    .smoothed_valid (out_ch.smoothed_valid),
    .rise_trip      (out_ch.rise_trip),
    .high_trip      (out_ch.high_trip)
);

`default_nettype wire
